### src/kth_ancestor_binary_lifting_assert.svh
// Assertion helpers for the binary lifting block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef KTH_ANCESTOR_BINARY_LIFTING_ASSERT_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define KAB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define KAB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/kab_pkg.sv
`timescale 1ns / 1ps
package kab_pkg;

	// width of a node id and of a step count
	localparam int NODE_W = 10;
	// number of distinct node ids
	localparam int NODE_IDS = 1 << NODE_W;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INS  = 5'b00010,
		ST_QHI  = 5'b00100,
		ST_QLO  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

### src/kab_req_if.sv
`timescale 1ns / 1ps
interface kab_req_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [kab_pkg::NODE_W-1:0] node;
	logic [kab_pkg::NODE_W-1:0] parent;
	logic [kab_pkg::NODE_W-1:0] steps;

	modport source(output valid, req_type, node, parent, steps, input ready);
	modport sink(input valid, req_type, node, parent, steps, output ready);
endinterface

### src/kab_rsp_if.sv
`timescale 1ns / 1ps
interface kab_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [kab_pkg::NODE_W-1:0] ancestor;

	modport source(output valid, ancestor, input ready);
	modport sink(input valid, ancestor, output ready);
endinterface

### src/kth_ancestor_binary_lifting.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                          Transaction
// req      in   req_type, node, parent, steps    insert a node or query an ancestor
// rsp      out  ancestor                         one per query, none per insert
//
// An insert writes the node's row from level 0 up to level LEVELS-1 before ready returns.
// A query climbs the top level steps >> (LEVELS-1) times or until it leaves the tree,
// then levels LEVELS-2 to 0; the single table read port serves one level per cycle.
// Reset clears control only; the table holds no valid bits and is undefined until written.
// A finished result waits in the output register; a new request is taken meanwhile, and a
// query only stalls in its last cycle while the previous result is still not taken.
module kth_ancestor_binary_lifting #(
	parameter int NODE_COUNT = 1024,
	parameter int LEVELS     = 10
) (
	input logic        clk,
	input logic        arst_n,
	kab_req_if.sink    req,
	kab_rsp_if.source  rsp
);

	`include "kth_ancestor_binary_lifting_assert.svh"

	localparam int NW     = kab_pkg::NODE_W;
	localparam int ROWS   = (NODE_COUNT < kab_pkg::NODE_IDS) ? NODE_COUNT : kab_pkg::NODE_IDS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int LVL_W  = $clog2(LEVELS);
	localparam int ADDR_W = ROW_W + LVL_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int LOW_W  = LEVELS - 1;
	localparam int EXT_W  = LEVELS + NW;
	localparam logic [NW:0]      LIMIT   = (NW + 1)'(ROWS);
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);
	localparam logic [LVL_W-1:0] LVL_LOW = LVL_W'(LEVELS - 2);

	kab_pkg::state_t state_q;

	logic [NW-1:0]    node_q;
	logic [NW-1:0]    cur_q;
	logic             use_rd_q;
	logic [NW-1:0]    rd_q;
	logic [LVL_W-1:0] lvl_q;
	logic [NW-1:0]    hi_q;
	logic [LOW_W-1:0] low_q;
	logic             out_valid_q;
	logic [NW-1:0]    out_q;

	logic [NW-1:0] mem [DEPTH];

	logic             in_acc;
	logic [NW-1:0]    cur;
	logic             cur_ok;
	logic             node_ok;
	logic             take;
	logic             fwd;
	logic             re;
	logic             we;
	logic [LVL_W-1:0] rd_lvl;
	logic [NW-1:0]    cur_nxt;
	logic             use_rd_nxt;
	logic [EXT_W-1:0] steps_ext;
	logic             out_free;

	// handshakes
	assign req.ready = (state_q == kab_pkg::ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign rsp.valid    = out_valid_q;
	assign rsp.ancestor = out_q;
	assign out_free     = !out_valid_q || rsp.ready;

	// current node of the walk: fresh table data or held value
	assign cur     = use_rd_q ? rd_q : cur_q;
	assign cur_ok  = (cur != '0) && ({1'b0, cur} < LIMIT);
	assign node_ok = (node_q != '0) && ({1'b0, node_q} < LIMIT);

	assign steps_ext = EXT_W'(req.steps);

	// decide whether the shared lookup applies this cycle, and at which level
	always_comb begin
		take   = 1'b0;
		rd_lvl = lvl_q;
		we     = 1'b0;
		case (state_q)
			kab_pkg::ST_INS: begin
				we   = node_ok;
				take = (lvl_q != LVL_TOP);
			end
			kab_pkg::ST_QHI: begin
				take   = (hi_q != '0);
				rd_lvl = LVL_TOP;
			end
			kab_pkg::ST_QLO: begin
				take = low_q[LOW_W-1];
			end
			default: begin
				take = 1'b0;
			end
		endcase
		// a self parent reads the entry written in this very cycle
		fwd = (state_q == kab_pkg::ST_INS) && (cur == node_q);
		re  = take && cur_ok && !fwd;
	end

	// next walk value
	always_comb begin
		cur_nxt    = cur;
		use_rd_nxt = 1'b0;
		if (take && !fwd) begin
			if (cur_ok) begin
				use_rd_nxt = 1'b1;
			end else begin
				cur_nxt = '0;
			end
		end
	end

	// ancestor table: one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[{node_q[ROW_W-1:0], lvl_q}] <= cur;
		end
		if (re) begin
			rd_q <= mem[{cur[ROW_W-1:0], rd_lvl}];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kab_pkg::ST_IDLE;
			use_rd_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// raise the result when the walk ends, drop it once taken
			if (state_q == kab_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				kab_pkg::ST_IDLE: begin
					use_rd_q <= 1'b0;
					if (in_acc) begin
						if (req.req_type == kab_pkg::REQ_INSERT) begin
							state_q <= kab_pkg::ST_INS;
						end else begin
							state_q <= kab_pkg::ST_QHI;
						end
					end
				end
				kab_pkg::ST_INS: begin
					use_rd_q <= use_rd_nxt;
					if (lvl_q == LVL_TOP) begin
						state_q <= kab_pkg::ST_IDLE;
					end
				end
				kab_pkg::ST_QHI: begin
					use_rd_q <= use_rd_nxt;
					if (hi_q == '0 || !cur_ok) begin
						state_q <= kab_pkg::ST_QLO;
					end
				end
				kab_pkg::ST_QLO: begin
					use_rd_q <= use_rd_nxt;
					if (lvl_q == '0) begin
						state_q <= kab_pkg::ST_FIN;
					end
				end
				kab_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= kab_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= kab_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		case (state_q)
			kab_pkg::ST_IDLE: begin
				if (in_acc) begin
					node_q <= req.node;
					hi_q   <= NW'(steps_ext >> (LEVELS - 1));
					low_q  <= steps_ext[LOW_W-1:0];
					if (req.req_type == kab_pkg::REQ_INSERT) begin
						cur_q <= req.parent;
						lvl_q <= '0;
					end else begin
						cur_q <= req.node;
						lvl_q <= LVL_LOW;
					end
				end
			end
			kab_pkg::ST_INS: begin
				cur_q <= cur_nxt;
				if (lvl_q != LVL_TOP) begin
					lvl_q <= lvl_q + 1'b1;
				end
			end
			kab_pkg::ST_QHI: begin
				cur_q <= cur_nxt;
				if (hi_q != '0) begin
					hi_q <= hi_q - 1'b1;
				end
			end
			kab_pkg::ST_QLO: begin
				cur_q <= cur_nxt;
				low_q <= low_q << 1;
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - 1'b1;
				end
			end
			kab_pkg::ST_FIN: begin
				if (out_free) begin
					out_q <= cur;
				end
			end
			default: begin
				cur_q <= cur;
			end
		endcase
	end

	`KAB_ASSERT_NEXT(a_ins_starts, in_acc && req.req_type == kab_pkg::REQ_INSERT, state_q == kab_pkg::ST_INS, "insert did not start the row fill")
	`KAB_ASSERT_NEXT(a_qry_starts, in_acc && req.req_type == kab_pkg::REQ_QUERY, state_q == kab_pkg::ST_QHI, "query did not start the climb")
	`KAB_ASSERT_SAME(a_rsp_src, $rose(out_valid_q), $past(state_q == kab_pkg::ST_FIN), "result raised outside the final step")
	`KAB_ASSERT_SAME(a_lvl_range, state_q == kab_pkg::ST_QLO, lvl_q <= LVL_LOW, "low climb level out of range")

endmodule

### test/tb_kth_ancestor_binary_lifting.sv
`timescale 1ns / 1ps
module tb_kth_ancestor_binary_lifting;

	localparam int NW             = kab_pkg::NODE_W;
	localparam int NODE_COUNT     = 1024;
	localparam int LEVELS         = 10;
	localparam int RANDOM_ITEMS   = 600;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 24;

	// Lifting table mirror and the queue of ancestors still owed by the block
	class ancestor_scoreboard;
		bit [NW-1:0] lift [NODE_COUNT][LEVELS];
		bit [NW-1:0] owed_q [$];
		int errors;

		function bit [NW-1:0] hop(bit [NW-1:0] n, int lvl);
			if (n == 0 || n >= NODE_COUNT || lvl >= LEVELS)
				return '0;
			return lift[n][lvl];
		endfunction

		// Apply an accepted request transaction to the mirror
		function void note_request(logic rt, logic [NW-1:0] node,
			logic [NW-1:0] parent, logic [NW-1:0] steps);
			bit [NW-1:0] cur;
			int high;
			if (rt == kab_pkg::REQ_INSERT) begin
				if (node != 0 && node < NODE_COUNT) begin
					lift[node][0] = parent;
					// fill upward; each level sees the levels just written
					for (int k = 1; k < LEVELS; k++)
						lift[node][k] = hop(lift[node][k-1], k - 1);
				end
			end else begin
				cur = node;
				high = int'(steps >> (LEVELS - 1));
				// climb the top level once per high step
				while (high != 0 && cur != 0) begin
					cur = hop(cur, LEVELS - 1);
					high--;
				end
				// then the remaining bits, high to low
				for (int k = LEVELS - 1; k > 0 && cur != 0; k--)
					if (steps[k-1])
						cur = hop(cur, k - 1);
				owed_q = {owed_q, cur};
			end
		endfunction

		// Compare a response transaction against the oldest owed ancestor
		function void check_answer(logic [NW-1:0] actual);
			bit [NW-1:0] want;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual ancestor %0d",
					$time, actual);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (actual !== want) begin
				$display("%0t: ancestor mismatch, expected %0d, actual %0d",
					$time, want, actual);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	kab_req_if req_if ();
	kab_rsp_if rsp_if ();

	kth_ancestor_binary_lifting #(
		.NODE_COUNT(NODE_COUNT),
		.LEVELS    (LEVELS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	ancestor_scoreboard sb = new();

	bit          known [NODE_COUNT];
	bit [NW-1:0] known_q [$];
	bit [NW-1:0] last_ins;
	bit          no_idle;
	int          idle_cycles;

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Reset and quiet inputs
	initial begin
		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.req_type = kab_pkg::REQ_INSERT;
		req_if.node     = '0;
		req_if.parent   = '0;
		req_if.steps    = '0;
		rsp_if.ready    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Observe both channels and count quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				sb.note_request(req_if.req_type, req_if.node, req_if.parent, req_if.steps);
			if (rsp_if.valid && rsp_if.ready)
				sb.check_answer(rsp_if.ancestor);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog
	initial begin
		idle_cycles = 0;
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("[kth_ancestor_binary_lifting] ERROR");
		$finish;
	end

	// Response side: stall a random number of cycles per transaction
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = no_idle ? 0 : int'($urandom_range(0, 16));
			if (gap != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
		end
	end

	// Drive one request transaction after a random gap
	task automatic send_request(logic rt, logic [NW-1:0] n, logic [NW-1:0] p,
		logic [NW-1:0] s);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 16));
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.req_type <= rt;
		req_if.node     <= n;
		req_if.parent   <= p;
		req_if.steps    <= s;
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
	endtask

	// Insert and remember which rows hold data
	task automatic insert_node(logic [NW-1:0] n, logic [NW-1:0] p);
		if (n != 0) begin
			if (!known[n])
				known_q = {known_q, n};
			known[n] = 1'b1;
			last_ins = n;
		end
		send_request(kab_pkg::REQ_INSERT, n, p,
			NW'($urandom_range(0, kab_pkg::NODE_IDS - 1)));
	endtask

	task automatic query_node(logic [NW-1:0] n, logic [NW-1:0] s);
		send_request(kab_pkg::REQ_QUERY, n,
			NW'($urandom_range(0, kab_pkg::NODE_IDS - 1)), s);
	endtask

	function automatic bit [NW-1:0] pick_known();
		return known_q[$urandom_range(0, known_q.size() - 1)];
	endfunction

	// Stimulus
	initial begin
		bit [NW-1:0] n;
		bit [NW-1:0] p;
		bit [NW-1:0] s;
		int r;
		no_idle = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// chain 1 <- 1023 <- 512 <- 2 <- ... <- 8, depth nine
		insert_node(1, 0);
		insert_node(1023, 1);
		insert_node(512, 1023);
		insert_node(2, 512);
		for (int i = 3; i <= 8; i++)
			insert_node(NW'(i), NW'(i - 1));
		// node zero insert is dropped
		insert_node(0, 5);
		// self parent, then a child of it
		insert_node(341, 341);
		insert_node(682, 341);
		query_node(8, 0);
		query_node(8, 1);
		query_node(8, 9);
		query_node(8, 10);
		query_node(8, 1023);
		query_node(341, 1023);
		query_node(682, 512);
		query_node(0, 5);
		query_node(1023, 1);
		query_node(1, 0);
		// re-parent the root below the deepest node to close a cycle
		insert_node(1, 8);
		query_node(8, 1023);

		// random mix, mostly well-formed tree growth and queries of known nodes
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 4) begin
				r = int'($urandom_range(0, 99));
				if (r < 5)
					n = 0;
				else if (r < 25 || known_q.size() >= NODE_COUNT - 1)
					n = pick_known();
				else begin
					do n = NW'($urandom_range(1, NODE_COUNT - 1)); while (known[n]);
				end
				r = int'($urandom_range(0, 99));
				if (n == 0)
					p = NW'($urandom_range(0, kab_pkg::NODE_IDS - 1));
				else if (r < 45)
					p = last_ins;
				else if (r < 75)
					p = pick_known();
				else if (r < 90)
					p = 0;
				else
					p = n;
				insert_node(n, p);
			end else begin
				n = ($urandom_range(0, 9) == 0) ? '0 : pick_known();
				r = int'($urandom_range(0, 99));
				if (r < 50)
					s = NW'($urandom_range(0, 40));
				else if (r < 75)
					s = NW'($urandom_range(0, kab_pkg::NODE_IDS - 1));
				else
					s = NW'(512 + $urandom_range(0, 40));
				query_node(n, s);
			end
		end
		req_if.valid <= 1'b0;

		// drain
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("[kth_ancestor_binary_lifting] OK");
		end else begin
			if (sb.owed_q.size() != 0)
				$display("%0t: %0d expected ancestors never arrived", $time, sb.owed_q.size());
			$display("[kth_ancestor_binary_lifting] ERROR");
		end
		$finish;
	end

endmodule

### kth_ancestor_binary_lifting.f
+incdir+src
src/kab_pkg.sv
src/kab_req_if.sv
src/kab_rsp_if.sv
src/kth_ancestor_binary_lifting.sv
test/tb_kth_ancestor_binary_lifting.sv
